// File: rtl/ast_pkg.sv
`timescale 1ns / 1ps

package ast_pkg;

  // width of the elapsed tick counters
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned LIMIT_WIDTH = 32;
  // compare width covers both the counters and the limit registers
  localparam int unsigned CMP_WIDTH   = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

  localparam int unsigned APB_DATA_WIDTH = 32;
  localparam int unsigned APB_ADDR_WIDTH = 4;
  localparam int unsigned REG_IDX_WIDTH  = 2;

  localparam logic [LIMIT_WIDTH-1:0] PUMP_PULSE_RST   = LIMIT_WIDTH'(10000);
  localparam logic [LIMIT_WIDTH-1:0] PUMP_LIMIT_RST   = LIMIT_WIDTH'(60000);
  localparam logic [LIMIT_WIDTH-1:0] FAN_LIMIT_RST    = LIMIT_WIDTH'(1800000);
  localparam logic [LIMIT_WIDTH-1:0] HEATER_LIMIT_RST = LIMIT_WIDTH'(1800000);

  typedef enum logic [REG_IDX_WIDTH-1:0] {
    REG_PUMP_PULSE   = 2'd0,
    REG_PUMP_LIMIT   = 2'd1,
    REG_FAN_LIMIT    = 2'd2,
    REG_HEATER_LIMIT = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_PUMP   = 3'd1,
    OP_FAN    = 3'd2,
    OP_LIGHT  = 3'd3,
    OP_HEATER = 3'd4
  } op_e;

  typedef struct packed {
    logic [LIMIT_WIDTH-1:0] pump_pulse_ms;
    logic [LIMIT_WIDTH-1:0] pump_limit_ms;
    logic [LIMIT_WIDTH-1:0] fan_limit_ms;
    logic [LIMIT_WIDTH-1:0] heater_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic       pump_state;
    logic       fan_state;
    logic [7:0] light_level;
    logic [7:0] heater_level;
    logic       pump_pulse_done;
    logic       pump_overrun;
    logic       fan_overrun;
    logic       heater_overrun;
  } res_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (c == {COUNT_WIDTH{1'b1}}) ? c : c + COUNT_WIDTH'(1);
  endfunction

  // counter reached limit, both zero-extended to a common width
  function automatic logic reached(input logic [COUNT_WIDTH-1:0] c,
                                   input logic [LIMIT_WIDTH-1:0] lim);
    return CMP_WIDTH'(c) >= CMP_WIDTH'(lim);
  endfunction

endpackage

// File: rtl/ast_cfg.sv
`timescale 1ns / 1ps

module ast_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ast_pkg::APB_ADDR_WIDTH-1:0]  paddr,
  input  logic [ast_pkg::APB_DATA_WIDTH-1:0]  pwdata,
  output logic [ast_pkg::APB_DATA_WIDTH-1:0]  prdata,
  output logic                                pready,
  output ast_pkg::cfg_t                       cfg_o
);

  ast_pkg::cfg_t     cfg_q;
  ast_pkg::reg_idx_e idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = ast_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pump_pulse_ms   <= ast_pkg::PUMP_PULSE_RST;
      cfg_q.pump_limit_ms   <= ast_pkg::PUMP_LIMIT_RST;
      cfg_q.fan_limit_ms    <= ast_pkg::FAN_LIMIT_RST;
      cfg_q.heater_limit_ms <= ast_pkg::HEATER_LIMIT_RST;
    end else if (wr_en) begin
      unique case (idx)
        ast_pkg::REG_PUMP_PULSE:   cfg_q.pump_pulse_ms   <= pwdata;
        ast_pkg::REG_PUMP_LIMIT:   cfg_q.pump_limit_ms   <= pwdata;
        ast_pkg::REG_FAN_LIMIT:    cfg_q.fan_limit_ms    <= pwdata;
        ast_pkg::REG_HEATER_LIMIT: cfg_q.heater_limit_ms <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ast_pkg::REG_PUMP_PULSE:   prdata = cfg_q.pump_pulse_ms;
      ast_pkg::REG_PUMP_LIMIT:   prdata = cfg_q.pump_limit_ms;
      ast_pkg::REG_FAN_LIMIT:    prdata = cfg_q.fan_limit_ms;
      ast_pkg::REG_HEATER_LIMIT: prdata = cfg_q.heater_limit_ms;
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/actuator_safety_timeout.sv
`timescale 1ns / 1ps

// safety timeouts for a pump, a fan and a heater, and a light level without a timeout
// input channel: in_valid_i / in_stall_o with operation_i and value_i; operation
//   tick advances all elapsed counters, pump, fan, light and heater each set one actuator
// output channel: out_valid_o / out_stall_i, one result per input transaction
//   with the actuator levels and the shutdown flags caused by that transaction
// latency: a result is valid the cycle after its input transaction is taken
// throughput: one transaction per cycle while in_stall_o is low; the state update and
//   the result are computed in one pass from the state registers into the result register
// when the receiver stalls, the result register holds and in_stall_o rises
//   until that result is taken; nothing is dropped or duplicated
// limits are written through the APB port (4 registers at 0x0, 0x4, 0x8, 0xc); the user
//   must write them only while no transaction is pending, which the block does not enforce
// reset: all actuators off, counters and levels zero, no result pending,
//   limits at 10000, 60000, 1800000 and 1800000 ticks

module actuator_safety_timeout (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [2:0]                          operation_i,
  input  logic [7:0]                          value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                pump_state_o,
  output logic                                fan_state_o,
  output logic [7:0]                          light_level_o,
  output logic [7:0]                          heater_level_o,
  output logic                                pump_pulse_done_o,
  output logic                                pump_overrun_o,
  output logic                                fan_overrun_o,
  output logic                                heater_overrun_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ast_pkg::APB_ADDR_WIDTH-1:0]  paddr,
  input  logic [ast_pkg::APB_DATA_WIDTH-1:0]  pwdata,
  output logic [ast_pkg::APB_DATA_WIDTH-1:0]  prdata,
  output logic                                pready
);

  localparam int unsigned CW = ast_pkg::COUNT_WIDTH;

  ast_pkg::cfg_t cfg;

  ast_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic          pump_run_q, pump_run_d;
  logic          fan_run_q, fan_run_d;
  logic [7:0]    heater_q, heater_d;
  logic [7:0]    light_q, light_d;
  logic [CW-1:0] pump_el_q, pump_el_d;
  logic [CW-1:0] fan_el_q, fan_el_d;
  logic [CW-1:0] heat_el_q, heat_el_d;
  logic          out_valid_q;
  ast_pkg::res_t res_q, res_d;
  logic          in_acc;
  logic          val_nz;
  logic          f_pulse, f_pover, f_fover, f_hover;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign val_nz     = (value_i != 8'd0);

  always_comb begin
    pump_run_d = pump_run_q;
    fan_run_d  = fan_run_q;
    heater_d   = heater_q;
    light_d    = light_q;
    pump_el_d  = pump_el_q;
    fan_el_d   = fan_el_q;
    heat_el_d  = heat_el_q;
    f_pulse    = 1'b0;
    f_pover    = 1'b0;
    f_fover    = 1'b0;
    f_hover    = 1'b0;
    unique case (ast_pkg::op_e'(operation_i))
      ast_pkg::OP_TICK: begin
        pump_el_d = ast_pkg::sat_inc(pump_el_q);
        fan_el_d  = ast_pkg::sat_inc(fan_el_q);
        heat_el_d = ast_pkg::sat_inc(heat_el_q);
        // pulse end wins over the runtime limit
        if (pump_run_q && ast_pkg::reached(pump_el_d, cfg.pump_pulse_ms)) begin
          pump_run_d = 1'b0;
          f_pulse    = 1'b1;
        end else if (pump_run_q && ast_pkg::reached(pump_el_d, cfg.pump_limit_ms)) begin
          pump_run_d = 1'b0;
          f_pover    = 1'b1;
        end
        if (fan_run_q && ast_pkg::reached(fan_el_d, cfg.fan_limit_ms)) begin
          fan_run_d = 1'b0;
          f_fover   = 1'b1;
        end
        if ((heater_q != 8'd0) && ast_pkg::reached(heat_el_d, cfg.heater_limit_ms)) begin
          heater_d = 8'd0;
          f_hover  = 1'b1;
        end
      end
      ast_pkg::OP_PUMP: begin
        // only an off-to-on edge restarts the pump timer
        if (val_nz && !pump_run_q) pump_el_d = '0;
        pump_run_d = val_nz;
      end
      ast_pkg::OP_FAN: begin
        if (val_nz) fan_el_d = '0;
        fan_run_d = val_nz;
      end
      ast_pkg::OP_LIGHT: begin
        light_d = value_i;
      end
      ast_pkg::OP_HEATER: begin
        if (val_nz) heat_el_d = '0;
        heater_d = value_i;
      end
      default: ;
    endcase

    res_d.pump_state      = pump_run_d;
    res_d.fan_state       = fan_run_d;
    res_d.light_level     = light_d;
    res_d.heater_level    = heater_d;
    res_d.pump_pulse_done = f_pulse;
    res_d.pump_overrun    = f_pover;
    res_d.fan_overrun     = f_fover;
    res_d.heater_overrun  = f_hover;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pump_run_q  <= 1'b0;
      fan_run_q   <= 1'b0;
      heater_q    <= 8'd0;
      light_q     <= 8'd0;
      pump_el_q   <= '0;
      fan_el_q    <= '0;
      heat_el_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        pump_run_q <= pump_run_d;
        fan_run_q  <= fan_run_d;
        heater_q   <= heater_d;
        light_q    <= light_d;
        pump_el_q  <= pump_el_d;
        fan_el_q   <= fan_el_d;
        heat_el_q  <= heat_el_d;
      end
      if (!in_stall_o) out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) res_q <= res_d;
  end

  assign out_valid_o       = out_valid_q;
  assign pump_state_o      = res_q.pump_state;
  assign fan_state_o       = res_q.fan_state;
  assign light_level_o     = res_q.light_level;
  assign heater_level_o    = res_q.heater_level;
  assign pump_pulse_done_o = res_q.pump_pulse_done;
  assign pump_overrun_o    = res_q.pump_overrun;
  assign fan_overrun_o     = res_q.fan_overrun;
  assign heater_overrun_o  = res_q.heater_overrun;

  a_pump_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(pump_pulse_done_o && pump_overrun_o))
    else $error("pump pulse end and overrun flagged together");

  a_pump_stop_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (pump_pulse_done_o || pump_overrun_o) |-> !pump_state_o)
    else $error("pump still on after a shutdown flag");

  a_fan_stop_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fan_overrun_o |-> !fan_state_o)
    else $error("fan still on after watchdog shutdown");

  a_heater_stop_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && heater_overrun_o |-> (heater_level_o == 8'd0))
    else $error("heater still powered after watchdog shutdown");

  a_cmd_no_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (operation_i != ast_pkg::OP_TICK) |=>
      !(pump_pulse_done_o || pump_overrun_o || fan_overrun_o || heater_overrun_o))
    else $error("shutdown flag raised by a command transaction");

endmodule
